// ----- rtl/single_source_shortest_path_unit_assert.svh -----
// Assertion macros used by the shortest path unit datapath (sssp_dpath).
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef SINGLE_SOURCE_SHORTEST_PATH_UNIT_ASSERT_SVH
`define SINGLE_SOURCE_SHORTEST_PATH_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSSP_ASSERT_SAME(lbl, ck, rst, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSSP_ASSERT_NEXT(lbl, ck, rst, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/sssp_pkg.sv -----
// Shared types, constants and the control program of the shortest path unit.
// Used by sssp_seq, sssp_dpath, single_source_shortest_path_unit and the testbench; no dependencies.
`default_nettype none

package sssp_pkg;

	localparam int MAX_NODES_DEF   = 64;
	localparam int WEIGHT_BITS_DEF = 16;

	localparam int NODE_FIELD_W = 6;
	localparam int NCOUNT_W     = 7;
	localparam int WEIGHT_IN_W  = 16;
	localparam int DIST_W       = 22;

	localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};
	localparam logic [DIST_W-1:0] DIST_MAX = {{(DIST_W-1){1'b1}}, 1'b0};

	localparam int NCOUNT_RESET = 64;

	localparam int STEP_W = 4;

	// Program step addresses.
	localparam logic [STEP_W-1:0] ST_CLR_INIT    = STEP_W'(0);
	localparam logic [STEP_W-1:0] ST_CLR_SWEEP   = STEP_W'(1);
	localparam logic [STEP_W-1:0] ST_IDLE        = STEP_W'(2);
	localparam logic [STEP_W-1:0] ST_INIT_DIST   = STEP_W'(3);
	localparam logic [STEP_W-1:0] ST_ROUND_INIT  = STEP_W'(4);
	localparam logic [STEP_W-1:0] ST_PICK_INIT   = STEP_W'(5);
	localparam logic [STEP_W-1:0] ST_PICK_RD     = STEP_W'(6);
	localparam logic [STEP_W-1:0] ST_PICK_CMP    = STEP_W'(7);
	localparam logic [STEP_W-1:0] ST_VISIT       = STEP_W'(8);
	localparam logic [STEP_W-1:0] ST_RELAX_RD    = STEP_W'(9);
	localparam logic [STEP_W-1:0] ST_RELAX_UPD   = STEP_W'(10);
	localparam logic [STEP_W-1:0] ST_ROUND_END   = STEP_W'(11);
	localparam logic [STEP_W-1:0] ST_EMIT_RD     = STEP_W'(12);
	localparam logic [STEP_W-1:0] ST_EMIT_PUT    = STEP_W'(13);
	localparam logic [STEP_W-1:0] ST_RUN_END     = STEP_W'(14);

	typedef enum logic [3:0] {
		OP_NOP,
		OP_CLR_INIT,
		OP_CLR_SWEEP,
		OP_IDLE,
		OP_INIT_DIST,
		OP_ROUND_INIT,
		OP_PICK_INIT,
		OP_PICK_RD,
		OP_PICK_CMP,
		OP_VISIT,
		OP_RELAX_RD,
		OP_RELAX_UPD,
		OP_EMIT_RD,
		OP_EMIT_PUT
	} op_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_CLR_MORE,
		COND_NOT_START,
		COND_V_MORE,
		COND_SRC_OUT,
		COND_ROUNDS_DONE,
		COND_BEST_INF
	} cond_t;

	typedef struct packed {
		op_t               op;
		cond_t             cond;
		logic [STEP_W-1:0] target;
	} ctl_word_t;

	typedef struct packed {
		logic v_more;
		logic clr_more;
		logic start;
		logic src_out;
		logic rounds_done;
		logic best_inf;
		logic hold;
	} status_t;

	// Control store: when the condition is true the sequencer jumps to target,
	// otherwise it falls through to the next step.
	function automatic ctl_word_t rom_word(input logic [STEP_W-1:0] step);
		ctl_word_t w;
		w = '{op: OP_NOP, cond: COND_ALWAYS, target: ST_CLR_INIT};
		case (step)
			ST_CLR_INIT:   w = '{op: OP_CLR_INIT,   cond: COND_NEVER,       target: ST_CLR_INIT};
			ST_CLR_SWEEP:  w = '{op: OP_CLR_SWEEP,  cond: COND_CLR_MORE,    target: ST_CLR_SWEEP};
			ST_IDLE:       w = '{op: OP_IDLE,       cond: COND_NOT_START,   target: ST_IDLE};
			ST_INIT_DIST:  w = '{op: OP_INIT_DIST,  cond: COND_V_MORE,      target: ST_INIT_DIST};
			ST_ROUND_INIT: w = '{op: OP_ROUND_INIT, cond: COND_SRC_OUT,     target: ST_EMIT_RD};
			ST_PICK_INIT:  w = '{op: OP_PICK_INIT,  cond: COND_ROUNDS_DONE, target: ST_EMIT_RD};
			ST_PICK_RD:    w = '{op: OP_PICK_RD,    cond: COND_NEVER,       target: ST_PICK_RD};
			ST_PICK_CMP:   w = '{op: OP_PICK_CMP,   cond: COND_V_MORE,      target: ST_PICK_RD};
			ST_VISIT:      w = '{op: OP_VISIT,      cond: COND_BEST_INF,    target: ST_PICK_INIT};
			ST_RELAX_RD:   w = '{op: OP_RELAX_RD,   cond: COND_NEVER,       target: ST_RELAX_RD};
			ST_RELAX_UPD:  w = '{op: OP_RELAX_UPD,  cond: COND_V_MORE,      target: ST_RELAX_RD};
			ST_ROUND_END:  w = '{op: OP_NOP,        cond: COND_ALWAYS,      target: ST_PICK_INIT};
			ST_EMIT_RD:    w = '{op: OP_EMIT_RD,    cond: COND_NEVER,       target: ST_EMIT_RD};
			ST_EMIT_PUT:   w = '{op: OP_EMIT_PUT,   cond: COND_V_MORE,      target: ST_EMIT_RD};
			ST_RUN_END:    w = '{op: OP_NOP,        cond: COND_ALWAYS,      target: ST_CLR_INIT};
			default:       w = '{op: OP_NOP,        cond: COND_ALWAYS,      target: ST_CLR_INIT};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/sssp_seq.sv -----
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on sssp_pkg for the control word, condition codes and program.
`default_nettype none

module sssp_seq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sssp_pkg::status_t status,
	output sssp_pkg::op_t         ctl_op
);

	logic [sssp_pkg::STEP_W-1:0] step_q;
	logic [sssp_pkg::STEP_W-1:0] step_next;
	sssp_pkg::ctl_word_t         word;
	logic                        jump;

	assign word   = sssp_pkg::rom_word(step_q);
	assign ctl_op = word.op;

	always_comb begin
		case (word.cond)
			sssp_pkg::COND_NEVER:       jump = 1'b0;
			sssp_pkg::COND_ALWAYS:      jump = 1'b1;
			sssp_pkg::COND_CLR_MORE:    jump = status.clr_more;
			sssp_pkg::COND_NOT_START:   jump = !status.start;
			sssp_pkg::COND_V_MORE:      jump = status.v_more;
			sssp_pkg::COND_SRC_OUT:     jump = status.src_out;
			sssp_pkg::COND_ROUNDS_DONE: jump = status.rounds_done;
			sssp_pkg::COND_BEST_INF:    jump = status.best_inf;
			default:                    jump = 1'b0;
		endcase
		// A held step repeats until the datapath can complete it.
		if (status.hold) begin
			step_next = step_q;
		end else if (jump) begin
			step_next = word.target;
		end else begin
			step_next = step_q + sssp_pkg::STEP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= sssp_pkg::ST_CLR_INIT;
		end else begin
			step_q <= step_next;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sssp_dpath.sv -----
// Datapath: adjacency and distance memories, visited flags, counters and result register.
// Depends on sssp_pkg and single_source_shortest_path_unit_assert.svh; driven by sssp_seq.
`default_nettype none

`include "single_source_shortest_path_unit_assert.svh"

module sssp_dpath #(
	parameter int MAX_NODES   = sssp_pkg::MAX_NODES_DEF,
	parameter int WEIGHT_BITS = sssp_pkg::WEIGHT_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire sssp_pkg::op_t                       ctl_op,
	output sssp_pkg::status_t                        status,
	input  wire logic [sssp_pkg::NCOUNT_W-1:0]       node_count,
	input  wire logic [sssp_pkg::NODE_FIELD_W-1:0]   source_node,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [sssp_pkg::NODE_FIELD_W-1:0]   from_node,
	input  wire logic [sssp_pkg::NODE_FIELD_W-1:0]   to_node,
	input  wire logic [sssp_pkg::WEIGHT_IN_W-1:0]    edge_weight,
	input  wire logic                                last_entry,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [sssp_pkg::NODE_FIELD_W-1:0]        node_index,
	output logic [sssp_pkg::DIST_W-1:0]              path_length,
	output logic                                     reachable,
	output logic                                     last_result
);

	localparam int DIST_W    = sssp_pkg::DIST_W;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int ADJ_DEPTH = MAX_NODES * MAX_NODES;
	localparam int ADJ_AW    = $clog2(ADJ_DEPTH);
	localparam int CMP_W     = ((NODE_W + 1) > sssp_pkg::NCOUNT_W) ? (NODE_W + 1)
		: sssp_pkg::NCOUNT_W;
	localparam int SUM_W     = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;

	logic [WEIGHT_BITS-1:0] adj_mem [ADJ_DEPTH];
	logic [DIST_W-1:0]      dist_mem [MAX_NODES];

	logic [WEIGHT_BITS-1:0] adj_rd_q;
	logic [DIST_W-1:0]      dist_rd_q;

	logic [MAX_NODES-1:0]   vis_q;
	logic [DIST_W-1:0]      best_q;
	logic [NODE_W-1:0]      idx_q;
	logic [NODE_W-1:0]      v_q;
	logic [NODE_W-1:0]      r_q;
	logic [ADJ_AW-1:0]      clr_q;

	logic                   out_valid_q;
	logic [sssp_pkg::NODE_FIELD_W-1:0] out_node_q;
	logic [DIST_W-1:0]      out_len_q;
	logic                   out_reach_q;
	logic                   out_last_q;

	logic [CMP_W-1:0]       nc_ext;
	logic [CMP_W-1:0]       n_eff;
	logic [NODE_W-1:0]      n_last;
	logic [CMP_W-1:0]       src_ext;
	logic [CMP_W-1:0]       from_ext;
	logic [CMP_W-1:0]       to_ext;
	logic [CMP_W-1:0]       v_ext;
	logic                   in_range;
	logic                   v_is_last;
	logic [NODE_W-1:0]      v_next;

	logic                   adj_we;
	logic [ADJ_AW-1:0]      adj_wa;
	logic [WEIGHT_BITS-1:0] adj_wd;
	logic                   adj_re;
	logic [ADJ_AW-1:0]      adj_ra;
	logic [ADJ_AW-1:0]      in_addr;

	logic                   dist_we;
	logic [DIST_W-1:0]      dist_wd;
	logic                   dist_re;

	logic [SUM_W-1:0]       sum;
	logic [DIST_W-1:0]      sum_sat;
	logic                   relax_upd;
	logic                   pick_take;
	logic                   hold;
	logic                   load_out;

	// Effective node count: zero behaves as one, large values clamp to the store size.
	assign nc_ext   = CMP_W'(node_count);
	assign n_eff    = (nc_ext == '0) ? CMP_W'(1)
		: ((nc_ext > CMP_W'(MAX_NODES)) ? CMP_W'(MAX_NODES) : nc_ext);
	assign n_last   = NODE_W'(n_eff - CMP_W'(1));
	assign src_ext  = CMP_W'(source_node);
	assign from_ext = CMP_W'(from_node);
	assign to_ext   = CMP_W'(to_node);
	assign v_ext    = CMP_W'(v_q);
	assign in_range = (from_ext < CMP_W'(MAX_NODES)) && (to_ext < CMP_W'(MAX_NODES));
	assign in_addr  = ADJ_AW'(ADJ_AW'(from_ext[NODE_W-1:0]) * ADJ_AW'(MAX_NODES))
		+ ADJ_AW'(to_ext[NODE_W-1:0]);

	assign v_is_last = (v_q == n_last);
	assign v_next    = v_is_last ? '0 : v_q + NODE_W'(1);

	assign sum       = SUM_W'(best_q) + SUM_W'(adj_rd_q);
	assign sum_sat   = (sum > SUM_W'(sssp_pkg::DIST_MAX)) ? sssp_pkg::DIST_MAX
		: sum[DIST_W-1:0];
	assign relax_upd = !vis_q[v_q] && (adj_rd_q != '0) && (sum_sat < dist_rd_q);
	assign pick_take = !vis_q[v_q] && (dist_rd_q <= best_q);

	assign hold     = (ctl_op == sssp_pkg::OP_EMIT_PUT) && out_valid_q && out_stall;
	assign load_out = (ctl_op == sssp_pkg::OP_EMIT_PUT) && !hold;
	assign in_stall = (ctl_op != sssp_pkg::OP_IDLE);

	assign status.v_more      = !v_is_last;
	assign status.clr_more    = (clr_q != ADJ_AW'(ADJ_DEPTH - 1));
	assign status.start       = in_valid && last_entry;
	assign status.src_out     = (src_ext >= n_eff);
	assign status.rounds_done = (r_q == n_last);
	assign status.best_inf    = (best_q == sssp_pkg::DIST_INF);
	assign status.hold        = hold;

	always_comb begin
		adj_we  = 1'b0;
		adj_wa  = clr_q;
		adj_wd  = '0;
		adj_re  = 1'b0;
		adj_ra  = ADJ_AW'(ADJ_AW'(idx_q) * ADJ_AW'(MAX_NODES)) + ADJ_AW'(v_q);
		dist_we = 1'b0;
		dist_wd = sum_sat;
		dist_re = 1'b0;
		case (ctl_op)
			sssp_pkg::OP_CLR_SWEEP: begin
				adj_we = 1'b1;
			end
			sssp_pkg::OP_IDLE: begin
				adj_we = in_valid && in_range;
				adj_wa = in_addr;
				adj_wd = WEIGHT_BITS'(edge_weight);
			end
			sssp_pkg::OP_INIT_DIST: begin
				dist_we = 1'b1;
				dist_wd = (v_ext == src_ext) ? '0 : sssp_pkg::DIST_INF;
			end
			sssp_pkg::OP_PICK_RD: begin
				dist_re = 1'b1;
			end
			sssp_pkg::OP_RELAX_RD: begin
				dist_re = 1'b1;
				adj_re  = 1'b1;
			end
			sssp_pkg::OP_RELAX_UPD: begin
				dist_we = relax_upd;
			end
			sssp_pkg::OP_EMIT_RD: begin
				dist_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adj_we) begin
			adj_mem[adj_wa] <= adj_wd;
		end
		if (adj_re) begin
			adj_rd_q <= adj_mem[adj_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[v_q] <= dist_wd;
		end
		if (dist_re) begin
			dist_rd_q <= dist_mem[v_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vis_q  <= '0;
			best_q <= sssp_pkg::DIST_INF;
			idx_q  <= '0;
			v_q    <= '0;
			r_q    <= '0;
			clr_q  <= '0;
		end else begin
			case (ctl_op)
				sssp_pkg::OP_CLR_INIT: begin
					vis_q <= '0;
					clr_q <= '0;
				end
				sssp_pkg::OP_CLR_SWEEP: begin
					clr_q <= clr_q + ADJ_AW'(1);
				end
				sssp_pkg::OP_IDLE: begin
					v_q <= '0;
				end
				sssp_pkg::OP_INIT_DIST: begin
					v_q <= v_next;
				end
				sssp_pkg::OP_ROUND_INIT: begin
					r_q <= '0;
				end
				sssp_pkg::OP_PICK_INIT: begin
					best_q <= sssp_pkg::DIST_INF;
					idx_q  <= '0;
					v_q    <= '0;
				end
				sssp_pkg::OP_PICK_CMP: begin
					// Less-or-equal keeps the highest index among equal distances.
					if (pick_take) begin
						best_q <= dist_rd_q;
						idx_q  <= v_q;
					end
					v_q <= v_next;
				end
				sssp_pkg::OP_VISIT: begin
					vis_q[idx_q] <= 1'b1;
					r_q          <= r_q + NODE_W'(1);
					v_q          <= '0;
				end
				sssp_pkg::OP_RELAX_UPD: begin
					v_q <= v_next;
				end
				sssp_pkg::OP_EMIT_PUT: begin
					if (!hold) begin
						v_q <= v_next;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_node_q  <= v_ext[sssp_pkg::NODE_FIELD_W-1:0];
			out_len_q   <= dist_rd_q;
			out_reach_q <= (dist_rd_q != sssp_pkg::DIST_INF);
			out_last_q  <= v_is_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign node_index  = out_node_q;
	assign path_length = out_len_q;
	assign reachable   = out_reach_q;
	assign last_result = out_last_q;

	`SSSP_ASSERT_SAME(a_relax_from_reached, clk, arst_n, ctl_op == sssp_pkg::OP_RELAX_UPD, best_q != sssp_pkg::DIST_INF, "relaxation started from an unreachable node")
	`SSSP_ASSERT_NEXT(a_visit_marks_node, clk, arst_n, ctl_op == sssp_pkg::OP_VISIT, vis_q[$past(idx_q)], "picked node was not marked visited")
	`SSSP_ASSERT_SAME(a_result_slot_free, clk, arst_n, load_out, !out_valid_q || !out_stall, "result register overwritten while its beat is stalled")

endmodule

`default_nettype wire

// ----- rtl/single_source_shortest_path_unit.sv -----
// Entries load one beat per cycle while in_stall is low; the last entry starts a run
// (distance setup, pick-and-relax rounds, then the result beats, one per node).
// One run at a time; each result is read, then put out, and out_stall holds it.
// Reset and the end of every run start a clearing pass over the adjacency memory,
// during which in_stall is high.
`default_nettype none

module single_source_shortest_path_unit #(
	parameter int MAX_NODES   = sssp_pkg::MAX_NODES_DEF,
	parameter int WEIGHT_BITS = sssp_pkg::WEIGHT_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [2:0]                        paddr,
	input  wire logic [31:0]                       pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [sssp_pkg::NODE_FIELD_W-1:0] from_node,
	input  wire logic [sssp_pkg::NODE_FIELD_W-1:0] to_node,
	input  wire logic [sssp_pkg::WEIGHT_IN_W-1:0]  edge_weight,
	input  wire logic                              last_entry,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [sssp_pkg::NODE_FIELD_W-1:0]      node_index,
	output logic [sssp_pkg::DIST_W-1:0]            path_length,
	output logic                                   reachable,
	output logic                                   last_result
);

	logic [sssp_pkg::NCOUNT_W-1:0]     node_count_q;
	logic [sssp_pkg::NODE_FIELD_W-1:0] source_node_q;
	logic                              cfg_wr;
	sssp_pkg::op_t                     ctl_op;
	sssp_pkg::status_t                 status;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// Register 0 (node count) sits at offset 0, register 1 (source node) at offset 4.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q  <= sssp_pkg::NCOUNT_W'(sssp_pkg::NCOUNT_RESET);
			source_node_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[2]) begin
				source_node_q <= pwdata[sssp_pkg::NODE_FIELD_W-1:0];
			end else begin
				node_count_q <= pwdata[sssp_pkg::NCOUNT_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2]) begin
			prdata = 32'(source_node_q);
		end else begin
			prdata = 32'(node_count_q);
		end
	end

	sssp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctl_op (ctl_op)
	);

	sssp_dpath #(
		.MAX_NODES   (MAX_NODES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl_op      (ctl_op),
		.status      (status),
		.node_count  (node_count_q),
		.source_node (source_node_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.from_node   (from_node),
		.to_node     (to_node),
		.edge_weight (edge_weight),
		.last_entry  (last_entry),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.node_index  (node_index),
		.path_length (path_length),
		.reachable   (reachable),
		.last_result (last_result)
	);

endmodule

`default_nettype wire

// ----- test/single_source_shortest_path_unit_test.sv -----
// Self-checking testbench for the single source shortest path unit.
// Loads adjacency entries, predicts every distance beat in the bench and
// compares it with the block; needs only sssp_pkg and the unit RTL.
`default_nettype none

module single_source_shortest_path_unit_test;

	localparam int MAX_N          = sssp_pkg::MAX_NODES_DEF;
	localparam int NODE_FIELD_W   = sssp_pkg::NODE_FIELD_W;
	localparam int NCOUNT_W       = sssp_pkg::NCOUNT_W;
	localparam int WEIGHT_IN_W    = sssp_pkg::WEIGHT_IN_W;
	localparam int DIST_W         = sssp_pkg::DIST_W;
	localparam logic [DIST_W-1:0] DIST_INF = sssp_pkg::DIST_INF;
	localparam logic [DIST_W-1:0] DIST_MAX = sssp_pkg::DIST_MAX;
	localparam int ITEM_TARGET    = 230;
	localparam int WATCHDOG_LIMIT = 100000;
	localparam int REPORT_LIMIT   = 10;

	localparam logic [2:0] REG_NODE_COUNT  = 3'd0;
	localparam logic [2:0] REG_SOURCE_NODE = 3'd4;

	typedef struct packed {
		logic [NODE_FIELD_W-1:0] node;
		logic [DIST_W-1:0]       len;
		logic                    reach;
		logic                    last;
	} path_beat_t;

	logic                    clk         = 1'b0;
	logic                    arst_n      = 1'b0;
	logic                    psel        = 1'b0;
	logic                    penable     = 1'b0;
	logic                    pwrite      = 1'b0;
	logic [2:0]              paddr       = '0;
	logic [31:0]             pwdata      = '0;
	logic [31:0]             prdata;
	logic                    pready;
	logic                    in_valid    = 1'b0;
	logic                    in_stall;
	logic [NODE_FIELD_W-1:0] from_node   = '0;
	logic [NODE_FIELD_W-1:0] to_node     = '0;
	logic [WEIGHT_IN_W-1:0]  edge_weight = '0;
	logic                    last_entry  = 1'b0;
	logic                    out_valid;
	logic                    out_stall   = 1'b0;
	logic [NODE_FIELD_W-1:0] node_index;
	logic [DIST_W-1:0]       path_length;
	logic                    reachable;
	logic                    last_result;

	single_source_shortest_path_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.from_node   (from_node),
		.to_node     (to_node),
		.edge_weight (edge_weight),
		.last_entry  (last_entry),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.node_index  (node_index),
		.path_length (path_length),
		.reachable   (reachable),
		.last_result (last_result)
	);

	// Bench copy of the block state.
	logic [WEIGHT_IN_W-1:0] edge_table [MAX_N][MAX_N];
	logic [NCOUNT_W-1:0]    cfg_node_count = NCOUNT_W'(sssp_pkg::NCOUNT_RESET);
	logic [NODE_FIELD_W-1:0] cfg_source    = '0;
	path_beat_t             expected_paths [$];

	int  mismatches    = 0;
	int  runs_done     = 0;
	int  entries_sent  = 0;
	int  beats_checked = 0;
	int  stall_left    = 0;
	int  idle_cycles   = 0;
	bit  sender_eager  = 1'b0;
	bit  receiver_eager = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int used_nodes();
		if (cfg_node_count == 0)
			return 1;
		if (cfg_node_count > MAX_N)
			return MAX_N;
		return int'(cfg_node_count);
	endfunction

	// Runs the search on the loaded matrix, queues one beat per node and
	// clears the matrix as the block does at the end of a run.
	function automatic void solve_shortest_paths();
		logic [DIST_W-1:0] node_dist [MAX_N];
		bit                seen [MAX_N];
		logic [DIST_W:0]   sum;
		logic [DIST_W-1:0] best;
		path_beat_t        beat;
		int                n, u, v, round;
		n = used_nodes();
		for (v = 0; v < n; v++) begin
			node_dist[v] = DIST_INF;
			seen[v] = 1'b0;
		end
		if (cfg_source < n) begin
			node_dist[cfg_source] = '0;
			for (round = 0; round + 1 < n; round++) begin
				best = DIST_INF;
				u = 0;
				// The <= keeps the highest index among equal distances.
				for (v = 0; v < n; v++) begin
					if (!seen[v] && node_dist[v] <= best) begin
						best = node_dist[v];
						u = v;
					end
				end
				seen[u] = 1'b1;
				if (node_dist[u] != DIST_INF) begin
					for (v = 0; v < n; v++) begin
						if (!seen[v] && edge_table[u][v] != 0) begin
							sum = {1'b0, node_dist[u]} + (DIST_W + 1)'(edge_table[u][v]);
							if (sum > {1'b0, DIST_MAX})
								sum = {1'b0, DIST_MAX};
							if (sum[DIST_W-1:0] < node_dist[v])
								node_dist[v] = sum[DIST_W-1:0];
						end
					end
				end
			end
		end
		for (v = 0; v < n; v++) begin
			beat.node  = NODE_FIELD_W'(v);
			beat.len   = node_dist[v];
			beat.reach = (node_dist[v] != DIST_INF);
			beat.last  = (v + 1 == n);
			expected_paths = {expected_paths, beat};
		end
		foreach (edge_table[i, j])
			edge_table[i][j] = '0;
		runs_done++;
	endfunction

	task automatic flag_mismatch(input string what, input path_beat_t want,
			input path_beat_t got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) begin
			$display("MISMATCH %s: expected node %0d len %0d reach %0b last %0b",
				what, want.node, want.len, want.reach, want.last);
			$display("         got node %0d len %0d reach %0b last %0b",
				got.node, got.len, got.reach, got.last);
		end
	endtask

	// Result side: checks each beat and draws the stall before the next one.
	always @(posedge clk) begin : take_result
		path_beat_t got;
		path_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {node_index, path_length, reachable, last_result};
			if (expected_paths.size() == 0) begin
				flag_mismatch("unexpected beat", '0, got);
			end else begin
				want = expected_paths.pop_front();
				if (got !== want)
					flag_mismatch("distance beat", want, got);
			end
			beats_checked++;
			if (last_result && $urandom_range(0, 3) == 0)
				receiver_eager = !receiver_eager;
			stall_left = receiver_eager ? 0 : $urandom_range(0, 8);
		end
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no beat moved for %0d cycles", idle_cycles);
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == REG_NODE_COUNT)
			cfg_node_count = value[NCOUNT_W-1:0];
		else if (addr == REG_SOURCE_NODE)
			cfg_source = value[NODE_FIELD_W-1:0];
		@(posedge clk);
	endtask

	// Holds off until every queued beat has arrived and the clearing pass is over.
	task automatic wait_idle();
		while (expected_paths.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_entry(input logic [5:0] f, input logic [5:0] t,
			input logic [15:0] w, input logic l);
		int gap;
		gap = sender_eager ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		from_node   <= f;
		to_node     <= t;
		edge_weight <= w;
		last_entry  <= l;
		do
			@(posedge clk);
		while (in_stall);
		entries_sent++;
		edge_table[f][t] = w;
		if (l) begin
			solve_shortest_paths();
			// The block is busy searching now, so dropping valid costs nothing.
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic test_single_node();
		wait_idle();
		write_reg(REG_NODE_COUNT, 32'd1);
		write_reg(REG_SOURCE_NODE, 32'd0);
		send_entry(6'd0, 6'd0, 16'd5, 1'b1);
		wait_idle();
		// A count of zero behaves as a single node.
		write_reg(REG_NODE_COUNT, 32'd0);
		send_entry(6'd63, 6'd63, 16'hFFFF, 1'b1);
		wait_idle();
		write_reg(REG_SOURCE_NODE, 32'd1);
		send_entry(6'd0, 6'd1, 16'd9, 1'b1);
	endtask

	task automatic test_ties_and_overwrites();
		wait_idle();
		write_reg(REG_NODE_COUNT, 32'd5);
		write_reg(REG_SOURCE_NODE, 32'd2);
		send_entry(6'd2, 6'd0, 16'd3, 1'b0);
		send_entry(6'd2, 6'd1, 16'd3, 1'b0);
		send_entry(6'd2, 6'd4, 16'd1, 1'b0);
		send_entry(6'd4, 6'd1, 16'd2, 1'b0);
		send_entry(6'd0, 6'd3, 16'hFFFF, 1'b0);
		send_entry(6'd2, 6'd3, 16'd7, 1'b0);
		// A zero weight removes the edge written just before.
		send_entry(6'd2, 6'd3, 16'd0, 1'b0);
		send_entry(6'd2, 6'd2, 16'd5, 1'b0);
		send_entry(6'd1, 6'd3, 16'hFFFF, 1'b1);
	endtask

	task automatic test_full_width_fields();
		wait_idle();
		write_reg(REG_NODE_COUNT, 32'd64);
		write_reg(REG_SOURCE_NODE, 32'd63);
		send_entry(6'd63, 6'd0, 16'hFFFF, 1'b0);
		send_entry(6'd0, 6'd62, 16'h0001, 1'b0);
		send_entry(6'd62, 6'd31, 16'hAAAA, 1'b0);
		send_entry(6'd31, 6'd32, 16'h5555, 1'b0);
		send_entry(6'd32, 6'd63, 16'h8000, 1'b1);
	endtask

	task automatic test_source_and_count_limits();
		wait_idle();
		write_reg(REG_NODE_COUNT, 32'd10);
		write_reg(REG_SOURCE_NODE, 32'd10);
		send_entry(6'd0, 6'd1, 16'd4, 1'b1);
		wait_idle();
		// Counts above the node limit are clamped to the full matrix.
		write_reg(REG_NODE_COUNT, 32'd127);
		write_reg(REG_SOURCE_NODE, 32'd40);
		send_entry(6'd40, 6'd63, 16'd1, 1'b0);
		send_entry(6'd63, 6'd0, 16'd2, 1'b1);
	endtask

	task automatic test_random_graphs();
		int         n, edges, k, pick, big_runs;
		logic [5:0] f, t;
		logic [15:0] w;
		big_runs = 0;
		while (entries_sent < ITEM_TARGET) begin
			sender_eager = ($urandom_range(0, 3) == 0);
			if (used_nodes() > 32 || $urandom_range(0, 1) == 1) begin
				wait_idle();
				pick = $urandom_range(0, 19);
				if (big_runs < 3 && pick == 0)
					n = $urandom_range(65, 127);
				else if (big_runs < 3 && pick == 1)
					n = $urandom_range(33, 64);
				else if (pick == 2)
					n = $urandom_range(0, 1);
				else
					n = $urandom_range(2, 12);
				write_reg(REG_NODE_COUNT, 32'(n));
				if ($urandom_range(0, 7) == 0)
					write_reg(REG_SOURCE_NODE, $urandom_range(0, 63));
				else
					write_reg(REG_SOURCE_NODE, $urandom_range(0, used_nodes() - 1));
			end
			n = used_nodes();
			if (n > 32) begin
				big_runs++;
				edges = $urandom_range(20, 40);
			end else begin
				edges = $urandom_range(1, (n * n < 22) ? n * n + 2 : 24);
			end
			for (k = 0; k < edges; k++) begin
				if ($urandom_range(0, 9) == 0) begin
					// Noise anywhere in the matrix, often outside the used nodes.
					f = NODE_FIELD_W'($urandom);
					t = NODE_FIELD_W'($urandom);
					w = WEIGHT_IN_W'($urandom);
				end else begin
					f = NODE_FIELD_W'($urandom_range(0, n - 1));
					t = NODE_FIELD_W'($urandom_range(0, n - 1));
					case ($urandom_range(0, 3))
						0: w = WEIGHT_IN_W'($urandom_range(1, 4));
						1: w = WEIGHT_IN_W'($urandom_range(1, 300));
						2: w = WEIGHT_IN_W'($urandom);
						default: w = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
					endcase
				end
				send_entry(f, t, w, k == edges - 1);
			end
		end
	endtask

	initial begin
		foreach (edge_table[i, j])
			edge_table[i][j] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_single_node();
		test_ties_and_overwrites();
		test_full_width_fields();
		test_source_and_count_limits();
		test_random_graphs();
		while (expected_paths.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("Ran %0d searches over %0d matrix entries and checked %0d distance beats,",
			runs_done, entries_sent, beats_checked);
		$display("including single-node, clamped-count and outside-source runs; %0d mismatches.",
			mismatches);
		if (mismatches == 0 && expected_paths.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/sssp_pkg.sv
rtl/sssp_seq.sv
rtl/sssp_dpath.sv
rtl/single_source_shortest_path_unit.sv
test/single_source_shortest_path_unit_test.sv
